### hw/rtl/mic_pkg.sv
// Shared types, constants and helpers for the 4x4 matrix inverse core.
// No dependencies; compiled first.
`default_nettype none

package mic_pkg;

  // Wide signed word for products, cofactors and the determinant
  localparam int WideW    = 136;
  localparam int ElemW    = 32;
  localparam int MulSteps = 32;

  localparam logic [ElemW-1:0] ValMax = 32'h7FFF_FFFF;
  localparam logic [ElemW-1:0] ValMin = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COF_INIT,
    ST_TERM_LD0,
    ST_TERM_LD1,
    ST_TERM_LD2,
    ST_MUL,
    ST_COF_DONE,
    ST_DET_CHECK,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } mic_state_e;

  typedef enum logic [1:0] {
    MUL_PAIR,
    MUL_TERM,
    MUL_DET
  } mic_mul_e;

  typedef struct packed {
    logic [1:0]              elem_row;
    logic [1:0]              elem_col;
    logic signed [ElemW-1:0] elem_value;
    logic                    compute;
  } mic_in_t;

  typedef struct packed {
    logic [1:0]              out_row;
    logic [1:0]              out_col;
    logic signed [ElemW-1:0] out_value;
    logic                    singular;
    logic                    last;
  } mic_out_t;

  // Column orders of a 3x3 minor; the last three are odd permutations
  localparam logic [1:0] Perm3 [6][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd2}
  };

  // Map minor index k (0..2) to a matrix index that skips ex
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] ex);
    return (k < ex) ? k : k + 2'd1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mic_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload type is supplied by the user, usually a struct from mic_pkg.
`default_nettype none

interface mic_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/matrix4_inverse_cofactor_core.sv
// 4x4 matrix inverse by adjugate, signed fixed point.
// Depends on mic_pkg and mic_stream_if.
//
// Usage: in_i carries load items (row, column, value, compute). Each transfer
// writes one element of a 16-entry matrix store. A transfer with compute set
// writes its element, then the core forms the determinant and emits 16 inverse
// entries on out_o in row-major order, last set on the final one. A zero
// determinant gives sixteen zero entries with singular set.
// A compute run is sequenced over one shared shift-add multiplier and one
// restoring divider, one bit per cycle: a cofactor is 6 terms of two
// multiplies, the determinant is 4 row-0 cofactors each scaled by one more
// multiply, and each output entry forms its cofactor and then its quotient.
// A singular matrix emits its sixteen zero entries straight after the
// determinant. in_i is not ready during a run.
// out_o is held in an output register; when the receiver stalls the core
// holds the pending entry and pauses. Reset clears the matrix store to zero
// and drops any run in progress.
`default_nettype none

module matrix4_inverse_cofactor_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  mic_stream_if.sink   in_i,
  mic_stream_if.source out_o
);
  import mic_pkg::*;

  localparam int DivW = WideW + 2 * FRAC_BITS + 1;
  localparam int CntW = $clog2(DivW);
  localparam int BitW = $clog2(MulSteps);

  mic_state_e state_q, state_d;
  mic_mul_e   kind_q;

  logic [ElemW-1:0]       store_q [16];
  logic signed [WideW-1:0] mx_q, macc_q, cacc_q, det_q;
  logic [ElemW-1:0]       my_q;
  logic [BitW-1:0]        bit_q;
  logic [2:0]             term_q;
  logic [1:0]             j_q;
  logic [3:0]             idx_q;
  logic                   out_phase_q, sing_q, neg_q;
  logic [DivW-1:0]        num_q;
  logic [WideW-1:0]       rem_q, d2_q;
  logic [ElemW-1:0]       quo_q;
  logic                   ovf_q;
  logic [CntW-1:0]        cnt_q;
  logic                   out_valid_q;
  mic_out_t               out_q;

  logic       in_fire, emit_go, mul_last, div_last;
  logic [1:0] ci, cj, rd_k, rd_row, rd_col;
  logic [3:0] rd_addr;
  logic [ElemW-1:0] rd_data;
  logic signed [WideW-1:0] rd_ext, addend, cmag, dmag;
  logic       term_neg;
  logic [WideW-1:0] rem_sh;
  logic       rem_ge;
  logic [ElemW-1:0] res_val;

  assign in_fire  = in_i.valid && in_i.ready;
  assign emit_go  = !out_valid_q || out_o.ready;
  assign mul_last = (bit_q == BitW'(MulSteps - 1));
  assign div_last = (cnt_q == CntW'(DivW - 1));

  // Cofactor being formed: det phase uses row 0, output phase cof(col,row)
  assign ci = out_phase_q ? idx_q[1:0] : 2'd0;
  assign cj = out_phase_q ? idx_q[3:2] : j_q;
  assign term_neg = (term_q >= 3'd3) ^ ci[0] ^ cj[0];

  always_comb begin
    unique case (state_q)
      ST_TERM_LD1: rd_k = 2'd1;
      ST_TERM_LD2: rd_k = 2'd2;
      default:     rd_k = 2'd0;
    endcase
  end

  assign rd_row  = skip_idx(rd_k, ci);
  assign rd_col  = skip_idx(Perm3[term_q][rd_k], cj);
  assign rd_addr = (state_q == ST_COF_DONE) ? {2'b00, j_q} : {rd_row, rd_col};
  assign rd_data = store_q[rd_addr];
  assign rd_ext  = {{(WideW - ElemW){rd_data[ElemW-1]}}, rd_data};

  // Bit 31 of the multiplier carries negative weight
  assign addend = my_q[0] ? (mul_last ? -mx_q : mx_q) : '0;

  assign cmag = cacc_q[WideW-1] ? -cacc_q : cacc_q;
  assign dmag = det_q[WideW-1] ? -det_q : det_q;

  assign rem_sh = {rem_q[WideW-2:0], num_q[DivW-1]};
  assign rem_ge = (rem_sh >= d2_q);

  always_comb begin
    if (sing_q) begin
      res_val = '0;
    end else if (ovf_q) begin
      res_val = neg_q ? ValMin : ValMax;
    end else if (neg_q) begin
      res_val = (quo_q > ValMin) ? ValMin : (ElemW'(0) - quo_q);
    end else begin
      res_val = (quo_q > ValMax) ? ValMax : quo_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire && in_i.data.compute) state_d = ST_COF_INIT;
      ST_COF_INIT:  state_d = ST_TERM_LD0;
      ST_TERM_LD0:  state_d = ST_TERM_LD1;
      ST_TERM_LD1:  state_d = ST_MUL;
      ST_TERM_LD2:  state_d = ST_MUL;
      ST_MUL: begin
        if (mul_last) begin
          unique case (kind_q)
            MUL_PAIR: state_d = ST_TERM_LD2;
            MUL_TERM: state_d = (term_q == 3'd5) ? ST_COF_DONE : ST_TERM_LD0;
            MUL_DET:  state_d = (j_q == 2'd3) ? ST_DET_CHECK : ST_COF_INIT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_COF_DONE:  state_d = out_phase_q ? ST_DIV_INIT : ST_MUL;
      ST_DET_CHECK: state_d = (det_q == '0) ? ST_EMIT : ST_COF_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV:       if (div_last) state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          if (idx_q == 4'd15) state_d = ST_IDLE;
          else                state_d = sing_q ? ST_EMIT : ST_COF_INIT;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    out_o.valid = out_valid_q;
    out_o.data  = out_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= MUL_PAIR;
      bit_q       <= '0;
      term_q      <= '0;
      j_q         <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_phase_q <= 1'b0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) store_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) store_q[{in_i.data.elem_row, in_i.data.elem_col}] <= in_i.data.elem_value;
      // Load a new entry, else drop the one the receiver took
      if (state_q == ST_EMIT && emit_go) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          j_q         <= '0;
          idx_q       <= '0;
          out_phase_q <= 1'b0;
          sing_q      <= 1'b0;
        end
        ST_COF_INIT: term_q <= '0;
        ST_TERM_LD1: begin
          kind_q <= MUL_PAIR;
          bit_q  <= '0;
        end
        ST_TERM_LD2: begin
          kind_q <= MUL_TERM;
          bit_q  <= '0;
        end
        ST_MUL: begin
          bit_q <= bit_q + BitW'(1);
          if (mul_last && kind_q == MUL_TERM) term_q <= term_q + 3'd1;
          if (mul_last && kind_q == MUL_DET)  j_q <= j_q + 2'd1;
        end
        ST_COF_DONE: begin
          kind_q <= MUL_DET;
          bit_q  <= '0;
        end
        ST_DET_CHECK: begin
          out_phase_q <= 1'b1;
          sing_q      <= (det_q == '0);
        end
        ST_DIV_INIT: cnt_q <= '0;
        ST_DIV:      cnt_q <= cnt_q + CntW'(1);
        ST_EMIT: begin
          if (emit_go) begin
            idx_q <= idx_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:     det_q <= '0;
      ST_COF_INIT: cacc_q <= '0;
      ST_TERM_LD0: begin
        mx_q   <= rd_ext;
        macc_q <= '0;
      end
      ST_TERM_LD1: my_q <= rd_data;
      ST_TERM_LD2: begin
        mx_q   <= term_neg ? -macc_q : macc_q;
        my_q   <= rd_data;
        macc_q <= cacc_q;
      end
      ST_MUL: begin
        macc_q <= macc_q + addend;
        mx_q   <= mx_q <<< 1;
        my_q   <= my_q >> 1;
        if (mul_last && kind_q == MUL_TERM) cacc_q <= macc_q + addend;
        if (mul_last && kind_q == MUL_DET)  det_q  <= macc_q + addend;
      end
      ST_COF_DONE: begin
        mx_q   <= cacc_q;
        my_q   <= rd_data;
        macc_q <= det_q;
      end
      ST_DIV_INIT: begin
        num_q <= (DivW'(unsigned'(cmag)) << (2 * FRAC_BITS + 1)) + DivW'(unsigned'(dmag));
        d2_q  <= WideW'(unsigned'(dmag)) << 1;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
        neg_q <= cacc_q[WideW-1] ^ det_q[WideW-1];
      end
      ST_DIV: begin
        num_q <= num_q << 1;
        rem_q <= rem_ge ? (rem_sh - d2_q) : rem_sh;
        quo_q <= {quo_q[ElemW-2:0], rem_ge};
        ovf_q <= ovf_q | quo_q[ElemW-1];
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_q.out_row   <= idx_q[3:2];
          out_q.out_col   <= idx_q[1:0];
          out_q.out_value <= res_val;
          out_q.singular  <= sing_q;
          out_q.last      <= (idx_q == 4'd15);
        end
      end
      default: ;
    endcase
  end

  // A compute transfer starts a run: no further load next cycle
  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.compute |=> !in_i.ready)
    else $error("input ready right after a compute transfer");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.last |-> out_o.data.out_row == 2'd3 && out_o.data.out_col == 2'd3)
    else $error("last flag not on final entry");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.singular |-> out_o.data.out_value == '0)
    else $error("singular entry with nonzero value");

  a_no_div_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !sing_q && d2_q != '0)
    else $error("divide with zero determinant");

endmodule

`default_nettype wire

### sim/tb_stream_if.sv
`timescale 1ns / 1ps
// Testbench-side notes for the stream channel.
// The channel interface itself comes from the RTL (mic_stream_if); this file holds only the idle percentage.

package tb_stream_pkg;
  localparam int IdlePct = 18;
endpackage

### sim/tb_top.sv
`timescale 1ns / 1ps
// Checks matrix4_inverse_cofactor_core: loads matrices element by element and predicts
// each adjugate inverse with exact wide arithmetic. Depends on mic_pkg, mic_stream_if, tb_stream_pkg.
module tb_top;
  import mic_pkg::*;

  localparam int Frac = 16;
  localparam int AccW = 256;
  localparam longint CycleLimit = 64'd12_000_000;

  // One row of the directed table; typed rows carry a diagonal-only expected inverse
  typedef struct {
    mic_in_t     it;
    bit          typed;
    bit          exp_sing;
    logic [31:0] exp_diag;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mic_stream_if #(.T(mic_in_t))  in_ch ();
  mic_stream_if #(.T(mic_out_t)) out_ch ();

  matrix4_inverse_cofactor_core #(.FRAC_BITS(Frac)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  logic [31:0] mat_shadow [16];
  mic_out_t inverse_q [$];
  int errors = 0;
  longint cycle_cnt = 0;
  bit steady = 0;
  bit typed_on = 0;
  bit typed_sing = 0;
  logic [31:0] typed_diag = '0;

  function automatic logic signed [AccW-1:0] elem(input int r, input int c);
    return {{(AccW-32){mat_shadow[r*4+c][31]}}, mat_shadow[r*4+c]};
  endfunction

  // exact cofactor of (i,j): signed 3x3 minor determinant
  function automatic logic signed [AccW-1:0] cofactor(input int i, input int j);
    int rw [3];
    int cl [3];
    int n, m;
    logic signed [AccW-1:0] d;
    n = 0;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      if (k != i) begin
        rw[n] = k;
        n++;
      end
      if (k != j) begin
        cl[m] = k;
        m++;
      end
    end
    d = elem(rw[0], cl[0]) * (elem(rw[1], cl[1]) * elem(rw[2], cl[2])
                              - elem(rw[1], cl[2]) * elem(rw[2], cl[1]))
      - elem(rw[0], cl[1]) * (elem(rw[1], cl[0]) * elem(rw[2], cl[2])
                              - elem(rw[1], cl[2]) * elem(rw[2], cl[0]))
      + elem(rw[0], cl[2]) * (elem(rw[1], cl[0]) * elem(rw[2], cl[1])
                              - elem(rw[1], cl[1]) * elem(rw[2], cl[0]));
    return ((i + j) % 2) ? -d : d;
  endfunction

  function automatic logic [31:0] scaled_quot(input logic signed [AccW-1:0] num,
                                              input logic signed [AccW-1:0] den);
    logic [AccW-1:0] an, ad, q;
    logic neg;
    neg = num[AccW-1] ^ den[AccW-1];
    an = num[AccW-1] ? -num : num;
    ad = den[AccW-1] ? -den : den;
    // round half away from zero on the magnitude
    q = ((an << (2*Frac + 1)) + ad) / (ad << 1);
    if (neg) return (q >= 64'h8000_0000) ? ValMin : -q[31:0];
    return (q > 64'h7FFF_FFFF) ? ValMax : q[31:0];
  endfunction

  task automatic predict_inverse(input mic_in_t it);
    logic signed [AccW-1:0] det;
    mic_out_t o;
    mat_shadow[{it.elem_row, it.elem_col}] = it.elem_value;
    if (!it.compute) return;
    det = '0;
    for (int j = 0; j < 4; j++) det += elem(0, j) * cofactor(0, j);
    for (int idx = 0; idx < 16; idx++) begin
      o.out_row = idx[3:2];
      o.out_col = idx[1:0];
      if (typed_on) begin
        o.singular = typed_sing;
        o.out_value = (idx[3:2] == idx[1:0]) ? typed_diag : '0;
      end else begin
        o.singular = (det == 0);
        o.out_value = o.singular ? '0 : scaled_quot(cofactor(idx % 4, idx / 4), det);
      end
      o.last = (idx == 15);
      inverse_q.push_back(o);
    end
  endtask

  // sink side: random stall, check each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      out_ch.ready <= steady || ($urandom_range(99) >= tb_stream_pkg::IdlePct);
      if (out_ch.valid && out_ch.ready) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_ch.data);
          errors++;
        end else begin
          mic_out_t e;
          e = inverse_q.pop_front();
          if (e.out_row != out_ch.data.out_row || e.out_col != out_ch.data.out_col
              || e.out_value != out_ch.data.out_value
              || e.singular != out_ch.data.singular || e.last != out_ch.data.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_ch.data);
            errors++;
          end
        end
      end
      if (cycle_cnt > CycleLimit) begin
        $display("matrix4_inverse_cofactor_core verification failed");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back items; idle cycles drop it
  task automatic send(input mic_in_t it);
    while (!steady && $urandom_range(99) < tb_stream_pkg::IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_inverse(it);
  endtask

  function automatic mic_in_t mk(input int r, input int c, input logic [31:0] v,
                                 input bit cmp);
    mic_in_t it;
    it.elem_row = r[1:0];
    it.elem_col = c[1:0];
    it.elem_value = v;
    it.compute = cmp;
    return it;
  endfunction

  function automatic dir_row_t dr(input mic_in_t it, input bit typed, input bit sing,
                                  input logic [31:0] diag);
    dir_row_t d;
    d.it = it;
    d.typed = typed;
    d.exp_sing = sing;
    d.exp_diag = diag;
    return d;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: return ValMax;
      2: return ValMin;
      3: return 32'h0001_0000;
      default: return {{15{1'($urandom_range(1))}}, 17'($urandom())};
    endcase
  endfunction

  dir_row_t directed [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int k = 0; k < 16; k++) mat_shadow[k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // zero store after reset is singular: all entries zero
    directed.push_back(dr(mk(3, 3, 32'h0, 1), 1, 1, 32'h0));
    // identity inverts to identity
    for (int k = 0; k < 4; k++) begin
      directed.push_back(dr(mk(k, k, 32'h0001_0000, k == 3), k == 3, 0, 32'h0001_0000));
    end
    // extremes on the diagonal, then off-diagonal values
    directed.push_back(dr(mk(0, 0, ValMax, 0), 0, 0, 32'h0));
    directed.push_back(dr(mk(1, 1, ValMin, 0), 0, 0, 32'h0));
    directed.push_back(dr(mk(2, 2, 32'h0000_0001, 0), 0, 0, 32'h0));
    directed.push_back(dr(mk(3, 2, 32'hFFFF_FFFF, 1), 0, 0, 32'h0));
    directed.push_back(dr(mk(0, 3, 32'hDEAD_BEEF, 0), 0, 0, 32'h0));
    directed.push_back(dr(mk(1, 3, ValMin, 1), 0, 0, 32'h0));
    foreach (directed[k]) begin
      typed_on = directed[k].typed;
      typed_sing = directed[k].exp_sing;
      typed_diag = directed[k].exp_diag;
      send(directed[k].it);
    end
    typed_on = 0;
    for (int n = 0; n < 340; n++) begin
      steady = (n >= 120 && n < 170);
      send(mk($urandom_range(3), $urandom_range(3), rand_val(), $urandom_range(19) == 0));
    end
    send(mk(2, 1, $urandom(), 1));
    in_ch.valid <= 1'b0;
    steady = 0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("matrix4_inverse_cofactor_core verification clean");
    end else begin
      $display("matrix4_inverse_cofactor_core verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/mic_pkg.sv
hw/rtl/mic_stream_if.sv
hw/rtl/matrix4_inverse_cofactor_core.sv
sim/tb_stream_if.sv
sim/tb_top.sv
